>>> rtl/lru_k_two_queue_replacer_unit_macros.svh
// Assertion macros used by the bound assertion checker.
`ifndef LRU_K_TWO_QUEUE_REPLACER_UNIT_MACROS_SVH
`define LRU_K_TWO_QUEUE_REPLACER_UNIT_MACROS_SVH
// Implication checked on every clock edge outside reset.
`define LKQ_ASSERT_IMPL(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("assertion failed");
// Next-cycle implication checked outside reset.
`define LKQ_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("assertion failed");
`endif

>>> rtl/lkq_pkg.sv
`timescale 1ns / 1ps
package lkq_pkg;
  localparam int unsigned ActW = 2;
  localparam int unsigned OutcomeW = 3;
  localparam int unsigned CountW = 8;
  localparam int unsigned CfgIdxW = 8;
  localparam int unsigned CfgDataW = 8;
  localparam int unsigned FieldKeyW = 32;
  localparam logic [CountW-1:0] CountMax = 8'd255;

  localparam logic [ActW-1:0] ActAccess = 2'd0;
  localparam logic [ActW-1:0] ActDumpHist = 2'd1;
  localparam logic [ActW-1:0] ActDumpCache = 2'd2;

  localparam logic [OutcomeW-1:0] OcCacheHit = 3'd0;
  localparam logic [OutcomeW-1:0] OcPromoted = 3'd1;
  localparam logic [OutcomeW-1:0] OcHistHit = 3'd2;
  localparam logic [OutcomeW-1:0] OcHistInsert = 3'd3;
  localparam logic [OutcomeW-1:0] OcDumpEntry = 3'd4;
  localparam logic [OutcomeW-1:0] OcDumpEmpty = 3'd5;

  localparam logic [CfgIdxW-1:0] RegThreshold = 8'd0;
  localparam logic [CfgIdxW-1:0] RegCapacity = 8'd1;

  typedef struct packed {
    logic [ActW-1:0] action;
    logic signed [FieldKeyW-1:0] key;
  } req_t;

  typedef struct packed {
    logic [OutcomeW-1:0] outcome;
    logic signed [FieldKeyW-1:0] result_key;
    logic [CountW-1:0] entry_count;
    logic evicted_valid;
    logic signed [FieldKeyW-1:0] evicted_key;
    logic last;
  } rsp_t;

  // Command broadcast to every cell of a queue in one update cycle.
  typedef struct packed {
    logic upd;      // apply a removal and/or append this cycle
    logic rem;      // remove the entry at rem_pos
    logic [6:0] rem_pos;
    logic app;      // append at position app_pos
    logic [6:0] app_pos;
    logic shift;    // dump rotation: every cell takes its upper neighbor
  } qcmd_t;
endpackage

>>> rtl/lru_k_two_queue_replacer_unit.sv
`timescale 1ns / 1ps
// LRU-K replacer with a history queue (keys and counts) and a cache queue.
// Command channel: an item is taken when start is high and busy is low.
// action 0 looks up key; action 1 or 2 dumps history or cache, oldest first.
// Results appear on rsp_o for one cycle each, marked by valid_o; the receiver
// cannot stall, so no back-pressure exists.
// Access: the key is registered when taken; in the look state it is compared
// in every cell, and the rows of cells that the outcome touches update at the
// same edge that registers the result. A dump gives one result a cycle for
// its N entries while the row makes a full rotation past its head, so every
// entry returns home; an empty dump gives a single empty result.
// The configuration channel (cfg_valid_i/cfg_ready_o) writes register 0, the
// promote threshold, or register 1, the capacity; it is always ready.
// Reset empties both queues and loads threshold 2 and capacity 16.
module lru_k_two_queue_replacer_unit #(
  parameter int unsigned QUEUE_DEPTH = 16,
  parameter int unsigned KEY_WIDTH = 32
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start,
  output logic                          busy,
  input  lkq_pkg::req_t                 req_i,
  output logic                          valid_o,
  output lkq_pkg::rsp_t                 rsp_o,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [lkq_pkg::CfgIdxW-1:0]   cfg_index_i,
  input  logic [lkq_pkg::CfgDataW-1:0]  cfg_data_i
);
  import lkq_pkg::*;

  localparam int unsigned PosW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned LenW = PosW + 1;
  localparam logic [LenW-1:0] DepthL = LenW'(QUEUE_DEPTH);

  typedef enum logic [1:0] {StIdle, StLook, StDump} state_e;

  state_e state_q, state_d;
  logic [7:0] thr_q, thr_d;
  logic [4:0] cap_q, cap_d;
  logic [LenW-1:0] hlen_q, clen_q, dcnt_q, dlen_q;
  logic [LenW-1:0] hlen_d, clen_d, dcnt_d, dlen_d;
  logic dhist_q, dhist_d;
  logic [KEY_WIDTH-1:0] key_q, key_d;
  logic [LenW-1:0] cap_eff;
  logic valid_d;
  rsp_t rsp_d;

  qcmd_t hcmd, ccmd;
  logic h_hit, c_hit;
  logic [PosW-1:0] h_pos, c_pos;
  logic [CountW-1:0] h_cnt, c_cnt_unused, h_head_cnt, c_head_cnt;
  logic [KEY_WIDTH-1:0] h_head, c_head;

  assign busy = (state_q != StIdle);
  assign cfg_ready_o = 1'b1;

  // Capacity clamped into 1..QUEUE_DEPTH.
  always_comb begin
    if (cap_q == 5'd0) cap_eff = LenW'(1);
    else if ({27'd0, cap_q} >= 32'(QUEUE_DEPTH)) cap_eff = DepthL;
    else cap_eff = LenW'(cap_q);
  end

  lkq_queue #(.Depth(QUEUE_DEPTH), .KeyW(KEY_WIDTH), .PosW(PosW)) u_hist (
    .clk_i, .cmd_i(hcmd), .cmp_key_i(key_q), .app_key_i(key_q),
    .app_cnt_i(h_hit ? ((h_cnt == CountMax) ? CountMax : h_cnt + 8'd1) : 8'd1),
    .len_i(hlen_q), .hit_o(h_hit), .hit_pos_o(h_pos), .hit_cnt_o(h_cnt),
    .head_key_o(h_head), .head_cnt_o(h_head_cnt)
  );

  lkq_queue #(.Depth(QUEUE_DEPTH), .KeyW(KEY_WIDTH), .PosW(PosW)) u_cache (
    .clk_i, .cmd_i(ccmd), .cmp_key_i(key_q), .app_key_i(key_q), .app_cnt_i(8'd0),
    .len_i(clen_q), .hit_o(c_hit), .hit_pos_o(c_pos), .hit_cnt_o(c_cnt_unused),
    .head_key_o(c_head), .head_cnt_o(c_head_cnt)
  );

  logic [CountW-1:0] nxt;
  logic promote, h_full, c_full;
  assign nxt = (h_cnt == CountMax) ? CountMax : h_cnt + 8'd1;
  assign promote = ({1'b0, h_cnt} + 9'd1) >= {1'b0, thr_q};
  assign h_full = hlen_q >= cap_eff;
  assign c_full = clen_q >= cap_eff;

  // Queue commands for the update cycle and rotation during dumps.
  always_comb begin
    hcmd = '0;
    ccmd = '0;
    if (state_q == StLook) begin
      if (c_hit) begin
        ccmd.upd = 1'b1; ccmd.rem = 1'b1; ccmd.rem_pos = 7'(c_pos);
        ccmd.app = 1'b1; ccmd.app_pos = 7'(clen_q);
      end else if (h_hit) begin
        hcmd.upd = 1'b1; hcmd.rem = 1'b1; hcmd.rem_pos = 7'(h_pos);
        if (promote) begin
          ccmd.upd = 1'b1; ccmd.rem = c_full; ccmd.rem_pos = 7'd0;
          ccmd.app = 1'b1; ccmd.app_pos = 7'(clen_q);
        end else begin
          hcmd.app = 1'b1; hcmd.app_pos = 7'(hlen_q);
        end
      end else begin
        hcmd.upd = 1'b1; hcmd.rem = h_full; hcmd.rem_pos = 7'd0;
        hcmd.app = 1'b1; hcmd.app_pos = 7'(hlen_q);
      end
    end else if (state_q == StDump) begin
      // Full-row rotation brings every entry past the head and back home.
      hcmd.shift = dhist_q;
      ccmd.shift = !dhist_q;
    end
  end

  // Sequencer next state, register writes and the next result.
  always_comb begin
    state_d = state_q;
    thr_d = thr_q;
    cap_d = cap_q;
    hlen_d = hlen_q;
    clen_d = clen_q;
    dcnt_d = dcnt_q;
    dlen_d = dlen_q;
    dhist_d = dhist_q;
    key_d = key_q;
    valid_d = 1'b0;
    rsp_d = rsp_o;
    if (cfg_valid_i) begin
      if (cfg_index_i == RegThreshold) thr_d = cfg_data_i;
      else if (cfg_index_i == RegCapacity) cap_d = cfg_data_i[4:0];
    end
    unique case (state_q)
      StIdle: begin
        if (start) begin
          key_d = KEY_WIDTH'(req_i.key);
          if (req_i.action == ActAccess) state_d = StLook;
          else if (req_i.action == ActDumpHist || req_i.action == ActDumpCache) begin
            dhist_d = (req_i.action == ActDumpHist);
            dlen_d = (req_i.action == ActDumpHist) ? hlen_q : clen_q;
            dcnt_d = '0;
            state_d = StDump;
          end
        end
      end
      StLook: begin
        state_d = StIdle;
        valid_d = 1'b1;
        rsp_d = '0;
        rsp_d.result_key = FieldKeyW'(key_q);
        rsp_d.last = 1'b1;
        if (c_hit) begin
          rsp_d.outcome = OcCacheHit;
        end else if (h_hit) begin
          rsp_d.entry_count = nxt;
          if (promote) begin
            rsp_d.outcome = OcPromoted;
            rsp_d.evicted_valid = c_full;
            hlen_d = hlen_q - LenW'(1);
            if (c_full) rsp_d.evicted_key = FieldKeyW'(c_head);
            else clen_d = clen_q + LenW'(1);
          end else begin
            rsp_d.outcome = OcHistHit;
          end
        end else begin
          rsp_d.outcome = OcHistInsert;
          rsp_d.entry_count = 8'd1;
          rsp_d.evicted_valid = h_full;
          if (h_full) rsp_d.evicted_key = FieldKeyW'(h_head);
          else hlen_d = hlen_q + LenW'(1);
        end
      end
      StDump: begin
        valid_d = 1'b1;
        rsp_d = '0;
        if (dlen_q == '0) begin
          rsp_d.outcome = OcDumpEmpty;
          rsp_d.last = 1'b1;
          state_d = StIdle;
        end else begin
          if (dcnt_q < dlen_q) begin
            rsp_d.outcome = OcDumpEntry;
            rsp_d.result_key = FieldKeyW'(dhist_q ? h_head : c_head);
            rsp_d.entry_count = dhist_q ? h_head_cnt : c_head_cnt;
            rsp_d.last = (dcnt_q + LenW'(1) == dlen_q);
          end else begin
            valid_d = 1'b0;
          end
          dcnt_d = dcnt_q + LenW'(1);
          // Finish the rotation of the whole row so entries return home.
          if (dcnt_q == LenW'(QUEUE_DEPTH - 1)) state_d = StIdle;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  // State, registers and the registered result.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      thr_q <= 8'd2;
      cap_q <= 5'd16;
      hlen_q <= '0;
      clen_q <= '0;
      dcnt_q <= '0;
      dlen_q <= '0;
      dhist_q <= 1'b0;
      key_q <= '0;
      valid_o <= 1'b0;
      rsp_o <= '0;
    end else begin
      state_q <= state_d;
      thr_q <= thr_d;
      cap_q <= cap_d;
      hlen_q <= hlen_d;
      clen_q <= clen_d;
      dcnt_q <= dcnt_d;
      dlen_q <= dlen_d;
      dhist_q <= dhist_d;
      key_q <= key_d;
      valid_o <= valid_d;
      rsp_o <= rsp_d;
    end
  end
endmodule

>>> rtl/lkq_cell.sv
`timescale 1ns / 1ps
module lkq_cell #(
  parameter int unsigned KeyW = 32,
  parameter int unsigned PosW = 4,
  parameter int unsigned Pos = 0
) (
  input  logic                      clk_i,
  input  lkq_pkg::qcmd_t            cmd_i,
  input  logic [KeyW-1:0]           cmp_key_i,
  input  logic [KeyW-1:0]           app_key_i,
  input  logic [lkq_pkg::CountW-1:0] app_cnt_i,
  input  logic [KeyW-1:0]           nb_key_i,
  input  logic [lkq_pkg::CountW-1:0] nb_cnt_i,
  output logic [KeyW-1:0]           key_o,
  output logic [lkq_pkg::CountW-1:0] cnt_o,
  output logic                      match_o
);
  import lkq_pkg::*;

  logic [KeyW-1:0]   key_q, key_d;
  logic [CountW-1:0] cnt_q, cnt_d;
  logic [6:0] me;
  logic [6:0] app_eff;

  assign me = 7'(Pos);
  assign match_o = (key_q == cmp_key_i);
  // With a removal the tail moves down one place before the append.
  assign app_eff = cmd_i.app_pos - {6'd0, cmd_i.rem};

  // Each cell keeps, takes its neighbor, or loads the appended entry.
  always_comb begin
    key_d = key_q;
    cnt_d = cnt_q;
    if (cmd_i.shift) begin
      key_d = nb_key_i;
      cnt_d = nb_cnt_i;
    end else if (cmd_i.upd) begin
      if (cmd_i.app && me == app_eff) begin
        key_d = app_key_i;
        cnt_d = app_cnt_i;
      end else if (cmd_i.rem && me >= cmd_i.rem_pos) begin
        key_d = nb_key_i;
        cnt_d = nb_cnt_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    key_q <= key_d;
    cnt_q <= cnt_d;
  end

  assign key_o = key_q;
  assign cnt_o = cnt_q;
endmodule

>>> rtl/lkq_queue.sv
`timescale 1ns / 1ps
module lkq_queue #(
  parameter int unsigned Depth = 16,
  parameter int unsigned KeyW = 32,
  parameter int unsigned PosW = 4
) (
  input  logic                       clk_i,
  input  lkq_pkg::qcmd_t             cmd_i,
  input  logic [KeyW-1:0]            cmp_key_i,
  input  logic [KeyW-1:0]            app_key_i,
  input  logic [lkq_pkg::CountW-1:0] app_cnt_i,
  input  logic [PosW:0]              len_i,
  output logic                       hit_o,
  output logic [PosW-1:0]            hit_pos_o,
  output logic [lkq_pkg::CountW-1:0] hit_cnt_o,
  output logic [KeyW-1:0]            head_key_o,
  output logic [lkq_pkg::CountW-1:0] head_cnt_o
);
  import lkq_pkg::*;

  logic [KeyW-1:0]   keys [Depth];
  logic [CountW-1:0] cnts [Depth];
  logic [Depth-1:0]  match;

  // Row of cells; each cell's upper neighbor feeds it, the top wraps to the head.
  for (genvar g = 0; g < Depth; g++) begin : g_cell
    localparam int unsigned Nb = (g + 1 < Depth) ? g + 1 : 0;
    lkq_cell #(.KeyW(KeyW), .PosW(PosW), .Pos(g)) u_cell (
      .clk_i, .cmd_i, .cmp_key_i, .app_key_i, .app_cnt_i,
      .nb_key_i(keys[Nb]), .nb_cnt_i(cnts[Nb]),
      .key_o(keys[g]), .cnt_o(cnts[g]), .match_o(match[g])
    );
  end

  // Keys are unique, so at most one valid cell matches.
  always_comb begin
    hit_o = 1'b0;
    hit_pos_o = '0;
    hit_cnt_o = '0;
    for (int i = 0; i < Depth; i++) begin
      if (match[i] && (PosW+1)'(i) < len_i) begin
        hit_o = 1'b1;
        hit_pos_o = PosW'(i);
        hit_cnt_o = cnts[i];
      end
    end
  end

  assign head_key_o = keys[0];
  assign head_cnt_o = cnts[0];
endmodule

>>> rtl/lkq_checker.sv
`timescale 1ns / 1ps
`include "lru_k_two_queue_replacer_unit_macros.svh"
module lkq_checker (
  input logic clk_i,
  input logic rst_ni,
  input logic start,
  input logic busy,
  input lkq_pkg::req_t req_i,
  input logic valid_o,
  input lkq_pkg::rsp_t rsp_o
);
  import lkq_pkg::*;
  // An accepted access or dump item makes the block busy.
  `LKQ_ASSERT_NEXT(a_start_busy, clk_i, rst_ni, start && !busy && (req_i.action == ActAccess || req_i.action == ActDumpHist || req_i.action == ActDumpCache), busy)
  // No result appears while idle except the one closing an item.
  `LKQ_ASSERT_IMPL(a_idle_quiet, clk_i, rst_ni, valid_o && !busy, rsp_o.last)
  // Dump and empty results never report an eviction.
  `LKQ_ASSERT_IMPL(a_dump_noev, clk_i, rst_ni,
    valid_o && (rsp_o.outcome == OcDumpEntry || rsp_o.outcome == OcDumpEmpty),
    !rsp_o.evicted_valid)
endmodule

bind lru_k_two_queue_replacer_unit lkq_checker u_lkq_checker (
  .clk_i, .rst_ni, .start, .busy, .req_i, .valid_o, .rsp_o
);

>>> sim/lru_k_replacer_checker.sv
`timescale 1ns / 1ps
// Watches the command, result and register channels of the replacer, keeps its
// own copy of both recency queues and checks every result item in order.
module lru_k_replacer_checker (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           start_i,
  input  logic           busy_i,
  input  lkq_pkg::req_t  req_i,
  input  logic           valid_i,
  input  lkq_pkg::rsp_t  rsp_i,
  input  logic           cfg_valid_i,
  input  logic           cfg_ready_i,
  input  logic [7:0]     cfg_index_i,
  input  logic [7:0]     cfg_data_i,
  output int             fail_count_o,
  output int             pending_o,
  output int             seen_count_o
);
  import lkq_pkg::*;

  localparam int unsigned Depth = 16;

  // Shadow copy of the block state.
  logic [31:0] hist_key_q [Depth];
  logic [7:0]  hist_cnt_q [Depth];
  int unsigned hist_len_q;
  logic [31:0] cache_key_q [Depth];
  int unsigned cache_len_q;
  logic [7:0]  threshold_q;
  logic [4:0]  capacity_q;

  rsp_t expected_rsp_q[$];

  function automatic rsp_t make_rsp(logic [2:0] oc, logic [31:0] k, logic [7:0] cnt,
                                    logic ev, logic [31:0] evk, logic lst);
    rsp_t r;
    r.outcome = oc;
    r.result_key = k;
    r.entry_count = cnt;
    r.evicted_valid = ev;
    r.evicted_key = evk;
    r.last = lst;
    return r;
  endfunction

  // Close the gap left by removing one history entry.
  task automatic hist_drop(int unsigned pos);
    for (int unsigned i = pos; i + 1 < hist_len_q && i + 1 < Depth; i++) begin
      hist_key_q[i] = hist_key_q[i+1];
      hist_cnt_q[i] = hist_cnt_q[i+1];
    end
    if (hist_len_q > 0) hist_len_q--;
  endtask

  task automatic cache_drop(int unsigned pos);
    for (int unsigned i = pos; i + 1 < cache_len_q && i + 1 < Depth; i++)
      cache_key_q[i] = cache_key_q[i+1];
    if (cache_len_q > 0) cache_len_q--;
  endtask

  // Apply one accepted command item and queue the results it should produce.
  task automatic replace_and_expect(req_t r);
    int unsigned cap;
    int cpos;
    int hpos;
    int unsigned len;
    logic [7:0] cnt;
    logic [7:0] nxt;
    logic ev;
    logic [31:0] evk;
    cap = (capacity_q < 1) ? 1 : ((capacity_q > Depth) ? Depth : capacity_q);
    cpos = -1;
    hpos = -1;
    ev = 1'b0;
    evk = '0;
    if (r.action == ActDumpHist || r.action == ActDumpCache) begin
      len = (r.action == ActDumpHist) ? hist_len_q : cache_len_q;
      if (len == 0) begin
        expected_rsp_q.push_back(make_rsp(OcDumpEmpty, '0, '0, 1'b0, '0, 1'b1));
      end else begin
        for (int unsigned i = 0; i < len; i++) begin
          if (r.action == ActDumpHist)
            expected_rsp_q.push_back(make_rsp(OcDumpEntry, hist_key_q[i], hist_cnt_q[i],
                                              1'b0, '0, i + 1 == len));
          else
            expected_rsp_q.push_back(make_rsp(OcDumpEntry, cache_key_q[i], '0,
                                              1'b0, '0, i + 1 == len));
        end
      end
    end else if (r.action == ActAccess) begin
      for (int unsigned i = 0; i < cache_len_q; i++)
        if (cpos < 0 && cache_key_q[i] == r.key) cpos = i;
      for (int unsigned i = 0; i < hist_len_q; i++)
        if (hpos < 0 && hist_key_q[i] == r.key) hpos = i;
      if (cpos >= 0) begin
        cache_drop(cpos);
        cache_key_q[cache_len_q] = r.key;
        cache_len_q++;
        expected_rsp_q.push_back(make_rsp(OcCacheHit, r.key, '0, 1'b0, '0, 1'b1));
      end else if (hpos >= 0) begin
        cnt = hist_cnt_q[hpos];
        nxt = (cnt == CountMax) ? CountMax : cnt + 8'd1;
        hist_drop(hpos);
        if ({1'b0, cnt} + 9'd1 >= {1'b0, threshold_q}) begin
          if (cache_len_q >= cap) begin
            ev = 1'b1;
            evk = cache_key_q[0];
            cache_drop(0);
          end
          cache_key_q[cache_len_q] = r.key;
          cache_len_q++;
          expected_rsp_q.push_back(make_rsp(OcPromoted, r.key, nxt, ev, evk, 1'b1));
        end else begin
          hist_key_q[hist_len_q] = r.key;
          hist_cnt_q[hist_len_q] = nxt;
          hist_len_q++;
          expected_rsp_q.push_back(make_rsp(OcHistHit, r.key, nxt, 1'b0, '0, 1'b1));
        end
      end else begin
        if (hist_len_q >= cap) begin
          ev = 1'b1;
          evk = hist_key_q[0];
          hist_drop(0);
        end
        hist_key_q[hist_len_q] = r.key;
        hist_cnt_q[hist_len_q] = 8'd1;
        hist_len_q++;
        expected_rsp_q.push_back(make_rsp(OcHistInsert, r.key, 8'd1, ev, evk, 1'b1));
      end
    end
  endtask

  task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      $error("%s mismatch: expected %0h, actual %0h", name, want, got);
      fail_count_o++;
    end
  endtask

  // Register writes, command items and result items, all sampled at the edge.
  always @(posedge clk_i or negedge rst_ni) begin
    rsp_t want;
    if (!rst_ni) begin
      hist_len_q = 0;
      cache_len_q = 0;
      threshold_q = 8'd2;
      capacity_q = 5'd16;
      expected_rsp_q.delete();
      fail_count_o = 0;
      seen_count_o = 0;
    end else begin
      if (cfg_valid_i && cfg_ready_i) begin
        if (cfg_index_i == RegThreshold) threshold_q = cfg_data_i;
        else if (cfg_index_i == RegCapacity) capacity_q = cfg_data_i[4:0];
      end
      if (valid_i) begin
        seen_count_o++;
        if (expected_rsp_q.size() == 0) begin
          $error("result item with no expectation waiting: %p", rsp_i);
          fail_count_o++;
        end else begin
          want = expected_rsp_q.pop_front();
          check_field("outcome", want.outcome, rsp_i.outcome);
          check_field("result_key", want.result_key, rsp_i.result_key);
          check_field("entry_count", want.entry_count, rsp_i.entry_count);
          check_field("evicted_valid", want.evicted_valid, rsp_i.evicted_valid);
          check_field("evicted_key", want.evicted_key, rsp_i.evicted_key);
          check_field("last", want.last, rsp_i.last);
        end
      end
      if (start_i && !busy_i) replace_and_expect(req_i);
    end
    pending_o = expected_rsp_q.size();
  end
endmodule

>>> sim/tb_lru_k_two_queue_replacer_unit.sv
`timescale 1ns / 1ps
// Drives command items and register writes into the replacer over several
// register settings and idle patterns; the checker gives the verdict data.
module tb_lru_k_two_queue_replacer_unit;
  import lkq_pkg::*;

  localparam logic [ActW-1:0] ActUnused = 2'd3;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic start = 1'b0;
  logic busy;
  req_t req_i = '0;
  logic valid_o;
  rsp_t rsp_o;
  logic cfg_valid_i = 1'b0;
  logic cfg_ready_o;
  logic [CfgIdxW-1:0] cfg_index_i = '0;
  logic [CfgDataW-1:0] cfg_data_i = '0;
  int fail_count;
  int pending;
  int seen_count;
  int sent_count = 0;
  int idle_pct = 0;
  logic [31:0] key_pool [24];

  always #5 clk_i = ~clk_i;

  lru_k_two_queue_replacer_unit uut (
    .clk_i, .rst_ni, .start, .busy, .req_i, .valid_o, .rsp_o,
    .cfg_valid_i, .cfg_ready_o, .cfg_index_i, .cfg_data_i
  );

  lru_k_replacer_checker checker_i (
    .clk_i, .rst_ni, .start_i(start), .busy_i(busy), .req_i, .valid_i(valid_o),
    .rsp_i(rsp_o), .cfg_valid_i, .cfg_ready_i(cfg_ready_o), .cfg_index_i,
    .cfg_data_i, .fail_count_o(fail_count), .pending_o(pending),
    .seen_count_o(seen_count)
  );

  // Send one command item; start stays high unless an idle gap is taken.
  task automatic send_item(logic [ActW-1:0] act, logic [31:0] k);
    if ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      repeat ($urandom_range(4, 1)) @(posedge clk_i);
    end
    start <= 1'b1;
    req_i <= '{action: act, key: k};
    forever begin
      @(negedge clk_i);
      if (!busy) break;
    end
    @(posedge clk_i);
    sent_count++;
  endtask

  // Lower start and wait until every expected result item has come.
  task automatic drain;
    start <= 1'b0;
    forever begin
      @(negedge clk_i);
      if (pending == 0) break;
    end
    @(posedge clk_i);
  endtask

  // Register write while idle, after the block has had time to finish a dump.
  task automatic write_reg(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] val);
    drain();
    repeat (20) @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= val;
    forever begin
      @(negedge clk_i);
      if (cfg_ready_o) break;
    end
    @(posedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  // Random items: mostly accesses to a small pool so hits and promotions occur.
  task automatic random_phase(int n, bit pause_often);
    int r;
    logic [31:0] k;
    for (int i = 0; i < n; i++) begin
      r = $urandom_range(99);
      k = (r < 85) ? key_pool[$urandom_range(23)] : $urandom;
      if (r < 80) send_item(ActAccess, k);
      else if (r < 88) send_item(ActDumpHist, $urandom);
      else if (r < 96) send_item(ActDumpCache, $urandom);
      else if (r < 98) send_item(ActUnused, $urandom);
      else send_item(ActAccess, $urandom);
      if (pause_often && i % 7 == 6) drain();
    end
  endtask

  initial begin
    foreach (key_pool[i]) key_pool[i] = $urandom;
    key_pool[0] = 32'h8000_0000;
    key_pool[1] = 32'h7fff_ffff;
    key_pool[2] = 32'h0;
    key_pool[3] = 32'hffff_ffff;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: empty dumps, the unused action, extreme keys, hits and promotions.
    send_item(ActDumpHist, 32'h0);
    send_item(ActDumpCache, 32'hffff_ffff);
    send_item(ActUnused, 32'h1234_5678);
    send_item(ActAccess, 32'h8000_0000);
    send_item(ActAccess, 32'h7fff_ffff);
    send_item(ActAccess, 32'h0);
    send_item(ActAccess, 32'hffff_ffff);
    send_item(ActAccess, 32'h8000_0000);
    send_item(ActAccess, 32'h8000_0000);
    send_item(ActAccess, 32'h7fff_ffff);
    send_item(ActDumpHist, 32'h0);
    send_item(ActDumpCache, 32'h0);
    send_item(ActAccess, 32'h7fff_ffff);
    write_reg(RegCapacity, 8'd1);
    send_item(ActAccess, 32'h0);
    send_item(ActAccess, 32'hffff_ffff);
    send_item(ActAccess, 32'h0);
    send_item(ActAccess, 32'h5555_aaaa);
    send_item(ActDumpHist, 32'h0);
    send_item(ActDumpCache, 32'h0);

    // Random phases over several register settings and idle patterns.
    write_reg(RegThreshold, 8'd3);
    write_reg(RegCapacity, 8'd16);
    idle_pct = 0;
    random_phase(15, 1'b0);
    write_reg(RegCapacity, 8'd4);
    idle_pct = 46;
    random_phase(15, 1'b1);
    write_reg(RegThreshold, 8'd255);
    write_reg(RegCapacity, 8'd0);
    idle_pct = 19;
    random_phase(15, 1'b0);
    write_reg(RegThreshold, 8'd0);
    write_reg(RegCapacity, 8'd31);
    idle_pct = 0;
    random_phase(15, 1'b0);
    write_reg(RegThreshold, 8'd1);
    write_reg(RegCapacity, 8'd8);
    idle_pct = 46;
    random_phase(15, 1'b0);
    write_reg(RegThreshold, 8'd2);
    write_reg(RegCapacity, 8'd16);
    idle_pct = 19;
    random_phase(15, 1'b0);

    drain();
    repeat (20) @(posedge clk_i);
    $display("Sent %0d command items over six register settings; checked %0d result items.",
             sent_count, seen_count);
    if (fail_count == 0 && pending == 0) begin
      $display("lru_k_two_queue_replacer_unit regression: pass");
    end else begin
      $display("lru_k_two_queue_replacer_unit regression: fail");
    end
    $finish;
  end

  // Watchdog for a hung handshake.
  initial begin
    #2_000_000;
    $display("lru_k_two_queue_replacer_unit regression: fail");
    $finish;
  end
endmodule

>>> sim.f
+incdir+rtl
rtl/lkq_pkg.sv
rtl/lkq_cell.sv
rtl/lkq_queue.sv
rtl/lru_k_two_queue_replacer_unit.sv
rtl/lkq_checker.sv
sim/lru_k_replacer_checker.sv
sim/tb_lru_k_two_queue_replacer_unit.sv
